// ----- rtl/grid_cell_range_diff_macros.svh -----
// Assertion macros for the grid cell range diff block.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef GRID_CELL_RANGE_DIFF_MACROS_SVH
`define GRID_CELL_RANGE_DIFF_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define GCRD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gcrd assertion failed");

// Next-cycle implication, disabled while reset is active.
`define GCRD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gcrd assertion failed");

`endif

// ----- rtl/gcrd_pkg.sv -----
// Shared types, codes and helpers for the grid cell range diff block.
// No dependencies; used by every module of the block.
package gcrd_pkg;

  localparam int GRID_MAX = 8;

  // Input modes
  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_MOVE   = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;

  // Cell operations
  localparam logic [1:0] OP_NONE   = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_CELL_SIZE = 2'd0;
  localparam logic [1:0] REG_GRID_COLS = 2'd1;
  localparam logic [1:0] REG_GRID_ROWS = 2'd2;

  localparam logic [12:0] CELL_SIZE_RST = 13'd16;
  localparam logic [3:0]  GRID_COLS_RST = 4'd8;
  localparam logic [3:0]  GRID_ROWS_RST = 4'd8;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [15:0]        size_w;
    logic [15:0]        size_h;
    logic [2:0]         old_row_first;
    logic [2:0]         old_row_last;
    logic [2:0]         old_col_first;
    logic [2:0]         old_col_last;
  } in_word_t;

  typedef struct packed {
    logic [2:0] cell_row;
    logic [2:0] cell_col;
    logic [1:0] cell_op;
    logic [2:0] new_row_first;
    logic [2:0] new_row_last;
    logic [2:0] new_col_first;
    logic [2:0] new_col_last;
    logic       last;
  } out_word_t;

  typedef struct packed {
    logic [12:0] cell_size;
    logic [3:0]  grid_cols;
    logic [3:0]  grid_rows;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic       load;
    logic       div_en;
    logic [1:0] div_sel;   // 0 top, 1 bottom, 2 left, 3 right
    logic [1:0] div_step;  // 0 load and range check, 1..3 quotient bits 2..0
    logic       setup;
    logic       scan;
    logic       finish;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic setup_empty;
    logic scan_last;
  } dp_stat_t;

  // Highest valid cell index for a grid dimension, clamped into 0..GRID_MAX-1.
  function automatic logic [2:0] grid_last(input logic [3:0] g);
    logic [2:0] res;
    if (g == 4'd0) begin
      res = 3'd0;
    end else if (g > 4'(GRID_MAX)) begin
      res = 3'(GRID_MAX - 1);
    end else begin
      res = 3'(g - 4'd1);
    end
    return res;
  endfunction

endpackage

// ----- rtl/gcrd_ctrl.sv -----
// Sequencer for the grid cell range diff block: divide, set up, scan, finish.
// Depends on gcrd_pkg for the command and status structs.
module gcrd_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  gcrd_pkg::dp_stat_t    stat_i,
  output gcrd_pkg::ctrl_cmd_t   cmd_o,
  output logic                  busy_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DIV    = 3'd1;
  localparam logic [2:0] ST_SETUP  = 3'd2;
  localparam logic [2:0] ST_SCAN   = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0] state_q, state_d;
  logic [3:0] cnt_q, cnt_d;  // {coordinate select, division step}

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = 4'd0;
          state_d    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_en   = 1'b1;
        cmd_o.div_sel  = cnt_q[3:2];
        cmd_o.div_step = cnt_q[1:0];
        cnt_d          = cnt_q + 4'd1;
        if (cnt_q == 4'hF) begin
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = stat_i.setup_empty ? ST_FINISH : ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_last) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= 4'd0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

// ----- rtl/gcrd_datapath.sv -----
// Datapath of the grid cell range diff block: shared quotient unit, scan
// counters, one-deep result lookahead and the output register. Uses gcrd_pkg.
module gcrd_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  gcrd_pkg::cfg_t        cfg_i,
  input  gcrd_pkg::in_word_t    in_i,
  input  gcrd_pkg::ctrl_cmd_t   cmd_i,
  output gcrd_pkg::dp_stat_t    stat_o,
  output logic                  res_strobe_o,
  output gcrd_pkg::out_word_t   res_o
);

  gcrd_pkg::in_word_t in_q;

  // Bounds: 0 row first, 1 row last, 2 col first, 3 col last
  logic [2:0] nb_q [4];

  // Quotient unit
  logic [16:0] rem_q, rem_d;
  logic [2:0]  quo_q, quo_d;
  logic        neg_q, neg_d;
  logic        sat_q, sat_d;
  logic [12:0] divisor;
  logic [15:0] w_eff, h_eff;
  logic [17:0] coord;
  logic [1:0]  shamt;
  logic [16:0] dshift;
  logic [16:0] rem_src;
  logic        ge;
  logic [1:0]  bit_idx;
  logic [2:0]  lim;
  logic [2:0]  bound;

  // Scan
  logic [2:0] r_q, c_q, sr1_q, sc0_q, sc1_q;
  logic       use_new_q, use_old_q;
  logic [2:0] rr0, rr1, rc0, rc1;
  logic       set_new, set_old, set_empty;
  logic       same;
  logic       isn, iso;
  logic [1:0] op;
  logic       hit;

  // Lookahead and output register
  logic       pend_valid_q;
  logic [2:0] pend_row_q, pend_col_q;
  logic [1:0] pend_op_q;
  logic       strobe_d;
  gcrd_pkg::out_word_t res_d;

  assign divisor = (cfg_i.cell_size == 13'd0) ? 13'd1 : cfg_i.cell_size;
  assign w_eff   = (in_q.size_w == 16'd0) ? 16'd1 : in_q.size_w;
  assign h_eff   = (in_q.size_h == 16'd0) ? 16'd1 : in_q.size_h;

  always_comb begin
    case (cmd_i.div_sel)
      2'd0:    coord = {{2{in_q.pos_y[15]}}, in_q.pos_y};
      2'd1:    coord = {{2{in_q.pos_y[15]}}, in_q.pos_y} + {2'b00, h_eff} - 18'd1;
      2'd2:    coord = {{2{in_q.pos_x[15]}}, in_q.pos_x};
      default: coord = {{2{in_q.pos_x[15]}}, in_q.pos_x} + {2'b00, w_eff} - 18'd1;
    endcase
  end

  // Step 0 checks against eight cells (anything at or past that clamps);
  // steps 1..3 restore one quotient bit each.
  assign shamt   = (cmd_i.div_step == 2'd0) ? 2'd3 : 2'(2'd3 - cmd_i.div_step);
  assign dshift  = {4'd0, divisor} << shamt;
  assign rem_src = (cmd_i.div_step == 2'd0) ? coord[16:0] : rem_q;
  assign ge      = (rem_src >= dshift);
  assign bit_idx = 2'(2'd3 - cmd_i.div_step);
  assign lim     = cmd_i.div_sel[1] ? gcrd_pkg::grid_last(cfg_i.grid_cols)
                                    : gcrd_pkg::grid_last(cfg_i.grid_rows);

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    neg_d = neg_q;
    sat_d = sat_q;
    if (cmd_i.div_step == 2'd0) begin
      rem_d = coord[16:0];
      quo_d = 3'd0;
      neg_d = coord[17];
      sat_d = ge;
    end else if (ge) begin
      rem_d          = rem_q - dshift;
      quo_d[bit_idx] = 1'b1;
    end
  end

  always_comb begin
    if (neg_q) begin
      bound = 3'd0;
    end else if (sat_q || (quo_d > lim)) begin
      bound = lim;
    end else begin
      bound = quo_d;
    end
  end

  // Scan rectangle per mode
  assign same = (in_q.old_row_first == nb_q[0]) && (in_q.old_row_last == nb_q[1]) &&
                (in_q.old_col_first == nb_q[2]) && (in_q.old_col_last == nb_q[3]);

  always_comb begin
    rr0       = nb_q[0];
    rr1       = nb_q[1];
    rc0       = nb_q[2];
    rc1       = nb_q[3];
    set_new   = 1'b0;
    set_old   = 1'b0;
    set_empty = 1'b1;
    case (in_q.mode)
      gcrd_pkg::MODE_ADD: begin
        set_new   = 1'b1;
        set_empty = 1'b0;
      end
      gcrd_pkg::MODE_MOVE: begin
        rr0       = (in_q.old_row_first < nb_q[0]) ? in_q.old_row_first : nb_q[0];
        rr1       = (in_q.old_row_last  > nb_q[1]) ? in_q.old_row_last  : nb_q[1];
        rc0       = (in_q.old_col_first < nb_q[2]) ? in_q.old_col_first : nb_q[2];
        rc1       = (in_q.old_col_last  > nb_q[3]) ? in_q.old_col_last  : nb_q[3];
        set_new   = 1'b1;
        set_old   = 1'b1;
        set_empty = same;
      end
      gcrd_pkg::MODE_REMOVE: begin
        rr0       = in_q.old_row_first;
        rr1       = in_q.old_row_last;
        rc0       = in_q.old_col_first;
        rc1       = in_q.old_col_last;
        set_old   = 1'b1;
        set_empty = (rr0 > rr1) || (rc0 > rc1);
      end
      default: begin
        set_empty = 1'b1;
      end
    endcase
  end

  assign isn = use_new_q && (r_q >= nb_q[0]) && (r_q <= nb_q[1]) &&
               (c_q >= nb_q[2]) && (c_q <= nb_q[3]);
  assign iso = use_old_q && (r_q >= in_q.old_row_first) && (r_q <= in_q.old_row_last) &&
               (c_q >= in_q.old_col_first) && (c_q <= in_q.old_col_last);

  always_comb begin
    if (isn && !iso) begin
      op = gcrd_pkg::OP_ADD;
    end else if (iso && !isn) begin
      op = gcrd_pkg::OP_REMOVE;
    end else begin
      op = gcrd_pkg::OP_NONE;
    end
  end

  assign hit = (op != gcrd_pkg::OP_NONE);

  assign stat_o.setup_empty = set_empty;
  assign stat_o.scan_last   = (r_q == sr1_q) && (c_q == sc1_q);

  // Release the held result when a newer one arrives; the final one goes out
  // with last set in the finish cycle, or a none result if nothing was held.
  always_comb begin
    strobe_d            = 1'b0;
    res_d.cell_row      = pend_row_q;
    res_d.cell_col      = pend_col_q;
    res_d.cell_op       = pend_op_q;
    res_d.new_row_first = nb_q[0];
    res_d.new_row_last  = nb_q[1];
    res_d.new_col_first = nb_q[2];
    res_d.new_col_last  = nb_q[3];
    res_d.last          = 1'b0;
    if (cmd_i.scan && hit && pend_valid_q) begin
      strobe_d = 1'b1;
    end else if (cmd_i.finish) begin
      strobe_d   = 1'b1;
      res_d.last = 1'b1;
      if (!pend_valid_q) begin
        res_d.cell_row = 3'd0;
        res_d.cell_col = 3'd0;
        res_d.cell_op  = gcrd_pkg::OP_NONE;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_q <= in_i;
    end
    if (cmd_i.div_en) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
      neg_q <= neg_d;
      sat_q <= sat_d;
      if (cmd_i.div_step == 2'd3) begin
        nb_q[cmd_i.div_sel] <= bound;
      end
    end
    if (cmd_i.setup) begin
      r_q       <= rr0;
      c_q       <= rc0;
      sr1_q     <= rr1;
      sc0_q     <= rc0;
      sc1_q     <= rc1;
      use_new_q <= set_new;
      use_old_q <= set_old;
    end else if (cmd_i.scan) begin
      if (c_q == sc1_q) begin
        c_q <= sc0_q;
        r_q <= r_q + 3'd1;
      end else begin
        c_q <= c_q + 3'd1;
      end
    end
    if (cmd_i.scan && hit) begin
      pend_row_q <= r_q;
      pend_col_q <= c_q;
      pend_op_q  <= op;
    end
    if (strobe_d) begin
      res_o <= res_d;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      res_strobe_o <= 1'b0;
    end else begin
      res_strobe_o <= strobe_d;
      if (cmd_i.load) begin
        pend_valid_q <= 1'b0;
      end else if (cmd_i.scan && hit) begin
        pend_valid_q <= 1'b1;
      end
    end
  end

endmodule

// ----- rtl/grid_cell_range_diff.sv -----
// Top level of the grid cell range diff block: configuration registers,
// sequencer and datapath. Depends on gcrd_pkg, gcrd_ctrl, gcrd_datapath.
//
//   channel  direction  handshake                 word
//   -------  ---------  ------------------------  -------------------------
//   input    in         start high, busy low      gcrd_pkg::in_word_t
//   result   out        res_strobe_o, one cycle   gcrd_pkg::out_word_t
//   config   in         cfg_valid_i & cfg_ready_o index 2b, data 13b
//
// A new item is taken only once the last one is through: its four cell
// bounds go through one shared quotient unit one after another, then one
// cell of the scanned rectangle (0..64 cells) is visited per cycle. Results
// appear in the cycle after the cell that releases them. The receiver cannot
// stall, so no result is ever held off. Reset returns to idle with cell size
// 16 and an 8 by 8 grid.
`include "grid_cell_range_diff_macros.svh"

module grid_cell_range_diff (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  gcrd_pkg::in_word_t    in_i,
  output logic                  res_strobe_o,
  output gcrd_pkg::out_word_t   res_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            cfg_index_i,
  input  logic [12:0]           cfg_data_i
);

  gcrd_pkg::cfg_t      cfg_q;
  gcrd_pkg::ctrl_cmd_t cmd;
  gcrd_pkg::dp_stat_t  stat;

  // Take configuration only while idle; unknown indexes are dropped.
  assign cfg_ready_o = !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cell_size <= gcrd_pkg::CELL_SIZE_RST;
      cfg_q.grid_cols <= gcrd_pkg::GRID_COLS_RST;
      cfg_q.grid_rows <= gcrd_pkg::GRID_ROWS_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        gcrd_pkg::REG_CELL_SIZE: cfg_q.cell_size <= cfg_data_i;
        gcrd_pkg::REG_GRID_COLS: cfg_q.grid_cols <= cfg_data_i[3:0];
        gcrd_pkg::REG_GRID_ROWS: cfg_q.grid_rows <= cfg_data_i[3:0];
        default: begin
        end
      endcase
    end
  end

  gcrd_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  gcrd_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_i        (in_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .res_strobe_o(res_strobe_o),
    .res_o       (res_o)
  );

  // An accepted item keeps the block busy on the next cycle.
  `GCRD_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy)
  // The final result leaves as the block returns to idle.
  `GCRD_ASSERT_IMPL(a_last_idle, clk_i, rst_ni, res_strobe_o && res_o.last, !busy)
  // Intermediate results only appear while an item is in work.
  `GCRD_ASSERT_IMPL(a_mid_busy, clk_i, rst_ni, res_strobe_o && !res_o.last, busy)

endmodule
